[hdl/hrhp_pkg.sv]
// shared types, constants and match helpers for the http response header parser
`default_nettype none

package hrhp_pkg;

   // parsing phase of the response
   typedef enum logic [3:0] {
      PH_SL_SPACE  = 4'd0,
      PH_PROTOCOL  = 4'd1,
      PH_ST_SPACE  = 4'd2,
      PH_STATUS    = 4'd3,
      PH_REASON    = 4'd4,
      PH_SL_LF     = 4'd5,
      PH_HDR_SPACE = 4'd6,
      PH_NAME      = 4'd7,
      PH_VAL_SPACE = 4'd8,
      PH_VALUE     = 4'd9,
      PH_HDR_LF    = 4'd10,
      PH_SEP_LF    = 4'd11,
      PH_BODY      = 4'd12,
      PH_ERROR     = 4'd13
   } phase_type;

   // item kind on the request channel
   typedef enum logic {
      KIND_DATA    = 1'b0,
      KIND_RESTART = 1'b1
   } kind_type;

   // tag given to each byte
   typedef enum logic [2:0] {
      CLS_DELIM    = 3'd0,
      CLS_PROTOCOL = 3'd1,
      CLS_STATUS   = 3'd2,
      CLS_REASON   = 3'd3,
      CLS_NAME     = 3'd4,
      CLS_VALUE    = 3'd5,
      CLS_BODY     = 3'd6,
      CLS_DROP     = 3'd7
   } byte_class_type;

   // known header names
   typedef enum logic [1:0] {
      HDR_OTHER          = 2'd0,
      HDR_CONTENT_LENGTH = 2'd1,
      HDR_CONTENT_TYPE   = 2'd2,
      HDR_LAST_MODIFIED  = 2'd3
   } hdr_id_type;

   // latched error codes
   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_PROTO = 2'd1,
      ERR_NO_LF = 2'd2
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]     byte_out;
      byte_class_type byte_class;
      hdr_id_type     header_id;
      logic           status_200;
      err_type        error_code;
   } rsp_type;

   // special characters
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;

   localparam logic [3:0] POS_MAX = 4'd15;

   // tokens to match
   localparam logic [3:0]       PROTO_LEN = 4'd8;
   localparam logic [0:7][7:0]  PROTO_STR = "HTTP/1.0";
   localparam logic [3:0]       OK_LEN    = 4'd3;
   localparam logic [0:2][7:0]  OK_STR    = "200";

   localparam logic [3:0]       CL_LEN  = 4'd14;
   localparam logic [3:0]       CT_LEN  = 4'd12;
   localparam logic [3:0]       LM_LEN  = 4'd13;
   localparam logic [0:13][7:0] NAME_CL = "Content-Length";
   localparam logic [0:13][7:0] NAME_CT = {"Content-Type", 16'h0000};
   localparam logic [0:13][7:0] NAME_LM = {"Last-Modified", 8'h00};

   // position counter step, saturating
   function automatic logic [3:0] pos_step(input logic [3:0] pos);
      logic [3:0] nxt;
      nxt = (pos == POS_MAX) ? POS_MAX : pos + 4'd1;
      return nxt;
   endfunction

   // byte does not continue the protocol token at this position
   function automatic logic proto_miss(input logic [3:0] pos, input logic [7:0] b);
      logic miss;
      miss = 1'b1;
      if (pos < PROTO_LEN) begin
         miss = (b != PROTO_STR[pos[2:0]]);
      end
      return miss;
   endfunction

   // byte does not continue the status token "200" at this position
   function automatic logic ok_miss(input logic [3:0] pos, input logic [7:0] b);
      logic miss;
      miss = 1'b1;
      if (pos < OK_LEN) begin
         miss = (b != OK_STR[pos[1:0]]);
      end
      return miss;
   endfunction

   // byte does not continue known header name idx at this position
   function automatic logic name_miss(input logic [1:0] idx, input logic [3:0] pos,
                                      input logic [7:0] b);
      logic miss;
      miss = 1'b1;
      case (idx)
         2'd0: if (pos < CL_LEN) miss = (b != NAME_CL[pos]);
         2'd1: if (pos < CT_LEN) miss = (b != NAME_CT[pos]);
         2'd2: if (pos < LM_LEN) miss = (b != NAME_LM[pos]);
         default: miss = 1'b1;
      endcase
      return miss;
   endfunction

   // known header that the name so far spells exactly
   function automatic hdr_id_type name_exact(input logic [2:0] flags, input logic [3:0] pos);
      hdr_id_type id;
      id = HDR_OTHER;
      if (flags[0] && pos == CL_LEN) id = HDR_CONTENT_LENGTH;
      else if (flags[1] && pos == CT_LEN) id = HDR_CONTENT_TYPE;
      else if (flags[2] && pos == LM_LEN) id = HDR_LAST_MODIFIED;
      return id;
   endfunction

endpackage

`default_nettype wire

[hdl/hrhp_if.sv]
// valid/ready channel interfaces for request bytes and tagged results
`default_nettype none

interface hrhp_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] data_byte;

   modport source (output valid, output kind, output data_byte, input ready);
   modport sink   (input valid, input kind, input data_byte, output ready);
   modport monitor (input valid, input ready, input kind, input data_byte);
endinterface

interface hrhp_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_out;
   logic [2:0] byte_class;
   logic [1:0] header_id;
   logic       status_200;
   logic [1:0] error_code;

   modport source (output valid, output byte_out, output byte_class, output header_id,
                   output status_200, output error_code, input ready);
   modport sink   (input valid, input byte_out, input byte_class, input header_id,
                   input status_200, input error_code, output ready);
   modport monitor (input valid, input ready, input byte_out, input byte_class,
                    input header_id, input status_200, input error_code);
endinterface

`default_nettype wire

[hdl/hrhp_in_reg.sv]
// input register stage holding one request item
`default_nettype none

module hrhp_in_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire hrhp_pkg::req_type in_item,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output hrhp_pkg::req_type     out_item
);

   logic              valid_ff;
   logic              valid_in;
   hrhp_pkg::req_type item_ff;

   // take a new item when empty or whenever the held one moves on
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

[hdl/hrhp_parse.sv]
// byte parser state and per-byte tagging logic
`default_nettype none

module hrhp_parse (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              step,
   input  wire hrhp_pkg::req_type item,
   output hrhp_pkg::rsp_type      result
);

   hrhp_pkg::phase_type  phase_ff, phase_in;
   logic [3:0]           tok_pos_ff, tok_pos_in;
   logic                 tok_mis_ff, tok_mis_in;
   logic [3:0]           name_pos_ff, name_pos_in;
   logic [2:0]           name_flags_ff, name_flags_in;
   hrhp_pkg::hdr_id_type cur_hdr_ff, cur_hdr_in;
   logic                 status_good_ff, status_good_in;
   hrhp_pkg::err_type    err_ff, err_in;

   logic [7:0]           b;
   logic [2:0]           first_flags;
   logic [2:0]           feed_flags;
   logic [3:0]           name_pos_next;
   logic                 tok_ok_proto;
   logic                 tok_ok_status;

   assign b = item.data_byte;

   // name match flags after one more byte, from a fresh name or the current one
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         first_flags[i] = !hrhp_pkg::name_miss(2'(i), 4'd0, b);
         feed_flags[i]  = name_flags_ff[i] && !hrhp_pkg::name_miss(2'(i), name_pos_ff, b);
      end
   end

   assign name_pos_next = hrhp_pkg::pos_step(name_pos_ff);
   assign tok_ok_proto  = !tok_mis_ff && (tok_pos_ff == hrhp_pkg::PROTO_LEN);
   assign tok_ok_status = !tok_mis_ff && (tok_pos_ff == hrhp_pkg::OK_LEN);

   // next state and tagged result
   always_comb begin
      phase_in       = phase_ff;
      tok_pos_in     = tok_pos_ff;
      tok_mis_in     = tok_mis_ff;
      name_pos_in    = name_pos_ff;
      name_flags_in  = name_flags_ff;
      cur_hdr_in     = cur_hdr_ff;
      status_good_in = status_good_ff;
      err_in         = err_ff;

      result.byte_out   = b;
      result.byte_class = hrhp_pkg::CLS_DELIM;
      result.header_id  = hrhp_pkg::HDR_OTHER;

      if (item.kind == hrhp_pkg::KIND_RESTART) begin
         phase_in          = hrhp_pkg::PH_SL_SPACE;
         tok_pos_in        = 4'd0;
         tok_mis_in        = 1'b0;
         name_pos_in       = 4'd0;
         name_flags_in     = 3'b111;
         cur_hdr_in        = hrhp_pkg::HDR_OTHER;
         status_good_in    = 1'b0;
         err_in            = hrhp_pkg::ERR_NONE;
         result.byte_out   = 8'h00;
         result.byte_class = hrhp_pkg::CLS_DROP;
      end else begin
         unique case (phase_ff) inside
            hrhp_pkg::PH_SL_SPACE: begin
               if (b != hrhp_pkg::CH_SP) begin
                  tok_pos_in        = 4'd1;
                  tok_mis_in        = hrhp_pkg::proto_miss(4'd0, b);
                  result.byte_class = hrhp_pkg::CLS_PROTOCOL;
                  phase_in          = hrhp_pkg::PH_PROTOCOL;
               end
            end
            hrhp_pkg::PH_PROTOCOL: begin
               if (b == hrhp_pkg::CH_SP) begin
                  if (tok_ok_proto) begin
                     tok_pos_in = 4'd0;
                     tok_mis_in = 1'b0;
                     phase_in   = hrhp_pkg::PH_ST_SPACE;
                  end else begin
                     err_in   = hrhp_pkg::ERR_PROTO;
                     phase_in = hrhp_pkg::PH_ERROR;
                  end
               end else begin
                  tok_mis_in        = tok_mis_ff | hrhp_pkg::proto_miss(tok_pos_ff, b);
                  tok_pos_in        = hrhp_pkg::pos_step(tok_pos_ff);
                  result.byte_class = hrhp_pkg::CLS_PROTOCOL;
               end
            end
            hrhp_pkg::PH_ST_SPACE: begin
               if (b != hrhp_pkg::CH_SP) begin
                  tok_pos_in        = 4'd1;
                  tok_mis_in        = hrhp_pkg::ok_miss(4'd0, b);
                  result.byte_class = hrhp_pkg::CLS_STATUS;
                  phase_in          = hrhp_pkg::PH_STATUS;
               end
            end
            hrhp_pkg::PH_STATUS: begin
               if (b == hrhp_pkg::CH_SP) begin
                  status_good_in = tok_ok_status;
                  phase_in       = hrhp_pkg::PH_REASON;
               end else begin
                  tok_mis_in        = tok_mis_ff | hrhp_pkg::ok_miss(tok_pos_ff, b);
                  tok_pos_in        = hrhp_pkg::pos_step(tok_pos_ff);
                  result.byte_class = hrhp_pkg::CLS_STATUS;
               end
            end
            hrhp_pkg::PH_REASON: begin
               if (b == hrhp_pkg::CH_CR) begin
                  phase_in = hrhp_pkg::PH_SL_LF;
               end else begin
                  result.byte_class = hrhp_pkg::CLS_REASON;
               end
            end
            hrhp_pkg::PH_SL_LF, hrhp_pkg::PH_HDR_LF: begin
               if (b == hrhp_pkg::CH_LF) begin
                  phase_in = hrhp_pkg::PH_HDR_SPACE;
               end else begin
                  err_in            = hrhp_pkg::ERR_NO_LF;
                  phase_in          = hrhp_pkg::PH_ERROR;
                  result.byte_class = hrhp_pkg::CLS_DROP;
               end
            end
            hrhp_pkg::PH_HDR_SPACE: begin
               if (b == hrhp_pkg::CH_CR) begin
                  phase_in = hrhp_pkg::PH_SEP_LF;
               end else if (b != hrhp_pkg::CH_SP) begin
                  name_pos_in       = 4'd1;
                  name_flags_in     = first_flags;
                  result.byte_class = hrhp_pkg::CLS_NAME;
                  result.header_id  = hrhp_pkg::name_exact(first_flags, 4'd1);
                  phase_in          = hrhp_pkg::PH_NAME;
               end
            end
            hrhp_pkg::PH_NAME: begin
               if (b == hrhp_pkg::CH_COLON) begin
                  cur_hdr_in       = hrhp_pkg::name_exact(name_flags_ff, name_pos_ff);
                  result.header_id = cur_hdr_in;
                  phase_in         = hrhp_pkg::PH_VAL_SPACE;
               end else begin
                  name_flags_in     = feed_flags;
                  name_pos_in       = name_pos_next;
                  result.byte_class = hrhp_pkg::CLS_NAME;
                  result.header_id  = hrhp_pkg::name_exact(feed_flags, name_pos_next);
               end
            end
            hrhp_pkg::PH_VAL_SPACE, hrhp_pkg::PH_VALUE: begin
               if (b == hrhp_pkg::CH_CR) begin
                  phase_in = hrhp_pkg::PH_HDR_LF;
               end else if (b != hrhp_pkg::CH_SP || phase_ff == hrhp_pkg::PH_VALUE) begin
                  result.byte_class = hrhp_pkg::CLS_VALUE;
                  result.header_id  = cur_hdr_ff;
                  phase_in          = hrhp_pkg::PH_VALUE;
               end
            end
            hrhp_pkg::PH_SEP_LF: begin
               if (b == hrhp_pkg::CH_LF) begin
                  phase_in = hrhp_pkg::PH_BODY;
               end else begin
                  err_in            = hrhp_pkg::ERR_NO_LF;
                  phase_in          = hrhp_pkg::PH_ERROR;
                  result.byte_class = hrhp_pkg::CLS_DROP;
               end
            end
            hrhp_pkg::PH_BODY: begin
               result.byte_class = hrhp_pkg::CLS_BODY;
            end
            default: begin
               result.byte_class = hrhp_pkg::CLS_DROP;
            end
         endcase
      end

      result.status_200 = status_good_in;
      result.error_code = err_in;
   end

   // parser state, updated as each item moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= hrhp_pkg::PH_SL_SPACE;
         tok_pos_ff     <= 4'd0;
         tok_mis_ff     <= 1'b0;
         name_pos_ff    <= 4'd0;
         name_flags_ff  <= 3'b111;
         cur_hdr_ff     <= hrhp_pkg::HDR_OTHER;
         status_good_ff <= 1'b0;
         err_ff         <= hrhp_pkg::ERR_NONE;
      end else if (step) begin
         phase_ff       <= phase_in;
         tok_pos_ff     <= tok_pos_in;
         tok_mis_ff     <= tok_mis_in;
         name_pos_ff    <= name_pos_in;
         name_flags_ff  <= name_flags_in;
         cur_hdr_ff     <= cur_hdr_in;
         status_good_ff <= status_good_in;
         err_ff         <= err_in;
      end
   end

endmodule

`default_nettype wire

[hdl/hrhp_out_reg.sv]
// result register that holds a tagged item until the receiver takes it
`default_nettype none

module hrhp_out_reg (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire hrhp_pkg::rsp_type in_item,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output hrhp_pkg::rsp_type      out_item
);

   logic              valid_ff;
   logic              valid_in;
   hrhp_pkg::rsp_type item_ff;

   // free when empty or when the held item leaves this cycle
   assign in_ready  = !valid_ff || out_ready;
   assign valid_in  = in_ready ? in_valid : valid_ff;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   // valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         item_ff <= in_item;
      end
   end

endmodule

`default_nettype wire

[hdl/http_response_header_parser_unit.sv]
// top level of the http/1.0 response header parser
// Usage:
//   req channel: one item per response byte (kind data) or a restart marker
//   (kind restart) that returns the parser to the start of a new response.
//   rsp channel: one tagged item for every request item, in order, carrying
//   the byte, its class, the known header it belongs to, the status flag and
//   the latched error code.
// Path: an accepted item passes the input register, then the result register,
//   where it shows on rsp and waits until the receiver takes it.
// Throughput: one item per cycle while rsp is not stalled; the parser state
//   machine decides a byte combinationally between the two registers.
// Reset: synchronous; both registers empty and the parser returns to the
//   start of a status line, same as after a restart item.
// Stall: while rsp is held off the result waits in its register and the
//   input register still accepts one more item; after that req_ready drops
//   until the result is taken.
`default_nettype none

module http_response_header_parser_unit (
   input  wire logic  clock,
   input  wire logic  reset,
   hrhp_req_if.sink   req,
   hrhp_rsp_if.source rsp
);

   hrhp_pkg::req_type req_item;
   hrhp_pkg::req_type s1_item;
   hrhp_pkg::rsp_type parse_result;
   hrhp_pkg::rsp_type rsp_item;
   logic              s1_valid;
   logic              s1_ready;
   logic              step;

   assign req_item.kind      = hrhp_pkg::kind_type'(req.kind);
   assign req_item.data_byte = req.data_byte;

   // input register
   hrhp_in_reg u_in_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req.valid),
      .in_ready  (req.ready),
      .in_item   (req_item),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_item  (s1_item)
   );

   // parser advances when the held item moves to the result register
   assign step = s1_valid && s1_ready;

   hrhp_parse u_parse (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .item   (s1_item),
      .result (parse_result)
   );

   // result register
   hrhp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_item   (parse_result),
      .out_valid (rsp.valid),
      .out_ready (rsp.ready),
      .out_item  (rsp_item)
   );

   assign rsp.byte_out   = rsp_item.byte_out;
   assign rsp.byte_class = rsp_item.byte_class;
   assign rsp.header_id  = rsp_item.header_id;
   assign rsp.status_200 = rsp_item.status_200;
   assign rsp.error_code = rsp_item.error_code;

endmodule

`default_nettype wire

[hdl/hrhp_checker.sv]
// port-level checks for the http response header parser, bound to the top level
`default_nettype none

module hrhp_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_byte_out,
   input wire logic [2:0] rsp_byte_class,
   input wire logic [1:0] rsp_header_id,
   input wire logic       rsp_status_200,
   input wire logic [1:0] rsp_error_code
);

   // nothing is offered in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

   // a stalled result item holds its payload
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte_out)
         && $stable(rsp_byte_class) && $stable(rsp_header_id)
         && $stable(rsp_status_200) && $stable(rsp_error_code))
      else $error("stalled rsp item changed");

   // a dropped item without error can only be the restart answer
   a_restart_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_class == hrhp_pkg::CLS_DROP
         && rsp_error_code == hrhp_pkg::ERR_NONE
      |-> rsp_byte_out == 8'h00 && rsp_header_id == hrhp_pkg::HDR_OTHER && !rsp_status_200)
      else $error("dropped item without error is not a clean restart answer");

   // a header id is only given on name, value or separator items
   a_hdr_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_header_id != hrhp_pkg::HDR_OTHER
      |-> rsp_byte_class == hrhp_pkg::CLS_NAME || rsp_byte_class == hrhp_pkg::CLS_VALUE
         || rsp_byte_class == hrhp_pkg::CLS_DELIM)
      else $error("header id on a byte outside a header line");

   // a bad protocol token can never come with a good status
   a_proto_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error_code == hrhp_pkg::ERR_PROTO |-> !rsp_status_200)
      else $error("status ok together with protocol error");

endmodule

bind http_response_header_parser_unit hrhp_checker u_hrhp_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_byte_out   (rsp.byte_out),
   .rsp_byte_class (rsp.byte_class),
   .rsp_header_id  (rsp.header_id),
   .rsp_status_200 (rsp.status_200),
   .rsp_error_code (rsp.error_code)
);

`default_nettype wire

[verif/tb.sv]
// testbench for the http response header parser: predicts each byte tag and checks every result
`timescale 1ns / 100ps

module tb;

   localparam int CYCLE_LIMIT = 1000000;

   // characters the parser reacts to
   localparam logic [7:0] SP_CHAR    = 8'h20;
   localparam logic [7:0] COLON_CHAR = 8'h3A;
   localparam logic [7:0] CR_CHAR    = 8'h0D;
   localparam logic [7:0] LF_CHAR    = 8'h0A;

   // tokens, right aligned in 14 byte fields
   localparam logic [111:0] PROTO_TXT = "HTTP/1.0";
   localparam logic [111:0] OK_TXT    = "200";

   logic clock;
   logic reset;

   hrhp_req_if req_bus();
   hrhp_rsp_if rsp_bus();

   http_response_header_parser_unit u_top (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   // parser state as predicted
   hrhp_pkg::phase_type  ps_phase;
   logic [3:0]           ps_tok_pos;
   logic                 ps_tok_bad;
   logic [3:0]           ps_name_pos;
   logic [2:0]           ps_name_hits;
   hrhp_pkg::hdr_id_type ps_hdr;
   logic                 ps_status_good;
   hrhp_pkg::err_type    ps_err;

   hrhp_pkg::rsp_type tags_due[$];
   hrhp_pkg::req_type byte_plan[$];
   int      miss_count = 0;
   int      sent_count = 0;
   int      cycle_count = 0;
   int      send_calm = 0;
   int      hold_left = 0;
   int      ready_calm = 0;

   always #6 clock = ~clock;

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] text_byte(input logic [111:0] txt, input int len,
                                            input int idx);
      return txt[8*(len-1-idx) +: 8];
   endfunction

   function automatic logic [111:0] hdr_txt(input int idx);
      logic [111:0] t;
      case (idx)
         0:       t = "Content-Length";
         1:       t = "Content-Type";
         default: t = "Last-Modified";
      endcase
      return t;
   endfunction

   function automatic int hdr_len(input int idx);
      int n;
      case (idx)
         0:       n = 14;
         1:       n = 12;
         default: n = 13;
      endcase
      return n;
   endfunction

   function automatic void parser_reset();
      ps_phase       = hrhp_pkg::PH_SL_SPACE;
      ps_tok_pos     = 4'd0;
      ps_tok_bad     = 1'b0;
      ps_name_pos    = 4'd0;
      ps_name_hits   = 3'b111;
      ps_hdr         = hrhp_pkg::HDR_OTHER;
      ps_status_good = 1'b0;
      ps_err         = hrhp_pkg::ERR_NONE;
   endfunction

   function automatic void tok_restart();
      ps_tok_pos = 4'd0;
      ps_tok_bad = 1'b0;
   endfunction

   // compare one byte against the token, position saturates at 15
   function automatic void tok_feed(input logic [111:0] txt, input int len,
                                    input logic [7:0] b);
      if (ps_tok_pos >= len) ps_tok_bad = 1'b1;
      else if (b != text_byte(txt, len, ps_tok_pos)) ps_tok_bad = 1'b1;
      if (ps_tok_pos != 4'd15) ps_tok_pos = ps_tok_pos + 4'd1;
   endfunction

   function automatic logic tok_done(input int len);
      return !ps_tok_bad && ps_tok_pos == len;
   endfunction

   // drop every known name that this byte does not continue
   function automatic void name_feed(input logic [7:0] b);
      int i;
      for (i = 0; i < 3; i++) begin
         if (ps_name_hits[i]) begin
            if (ps_name_pos >= hdr_len(i)) ps_name_hits[i] = 1'b0;
            else if (b != text_byte(hdr_txt(i), hdr_len(i), ps_name_pos))
               ps_name_hits[i] = 1'b0;
         end
      end
      if (ps_name_pos != 4'd15) ps_name_pos = ps_name_pos + 4'd1;
   endfunction

   function automatic hrhp_pkg::hdr_id_type name_match();
      hrhp_pkg::hdr_id_type id;
      id = hrhp_pkg::HDR_OTHER;
      if (ps_name_hits[0] && ps_name_pos == hdr_len(0)) id = hrhp_pkg::HDR_CONTENT_LENGTH;
      else if (ps_name_hits[1] && ps_name_pos == hdr_len(1)) id = hrhp_pkg::HDR_CONTENT_TYPE;
      else if (ps_name_hits[2] && ps_name_pos == hdr_len(2)) id = hrhp_pkg::HDR_LAST_MODIFIED;
      return id;
   endfunction

   function automatic void raise_error(input hrhp_pkg::err_type code);
      ps_err   = code;
      ps_phase = hrhp_pkg::PH_ERROR;
   endfunction

   // tag of one byte, advancing the predicted parser state
   function automatic hrhp_pkg::rsp_type tag_byte(input hrhp_pkg::req_type it);
      hrhp_pkg::rsp_type        r;
      logic [7:0]               b;
      hrhp_pkg::byte_class_type cls;
      hrhp_pkg::hdr_id_type     hid;
      b   = it.data_byte;
      cls = hrhp_pkg::CLS_DELIM;
      hid = hrhp_pkg::HDR_OTHER;
      if (it.kind == hrhp_pkg::KIND_RESTART) begin
         parser_reset();
         r.byte_out   = 8'h00;
         r.byte_class = hrhp_pkg::CLS_DROP;
         r.header_id  = hrhp_pkg::HDR_OTHER;
         r.status_200 = 1'b0;
         r.error_code = hrhp_pkg::ERR_NONE;
         return r;
      end
      case (ps_phase) inside
         hrhp_pkg::PH_SL_SPACE: begin
            if (b != SP_CHAR) begin
               tok_restart();
               tok_feed(PROTO_TXT, 8, b);
               cls      = hrhp_pkg::CLS_PROTOCOL;
               ps_phase = hrhp_pkg::PH_PROTOCOL;
            end
         end
         hrhp_pkg::PH_PROTOCOL: begin
            if (b == SP_CHAR) begin
               if (tok_done(8)) begin
                  tok_restart();
                  ps_phase = hrhp_pkg::PH_ST_SPACE;
               end else begin
                  raise_error(hrhp_pkg::ERR_PROTO);
               end
            end else begin
               tok_feed(PROTO_TXT, 8, b);
               cls = hrhp_pkg::CLS_PROTOCOL;
            end
         end
         hrhp_pkg::PH_ST_SPACE: begin
            if (b != SP_CHAR) begin
               tok_restart();
               tok_feed(OK_TXT, 3, b);
               cls      = hrhp_pkg::CLS_STATUS;
               ps_phase = hrhp_pkg::PH_STATUS;
            end
         end
         hrhp_pkg::PH_STATUS: begin
            if (b == SP_CHAR) begin
               ps_status_good = tok_done(3);
               ps_phase       = hrhp_pkg::PH_REASON;
            end else begin
               tok_feed(OK_TXT, 3, b);
               cls = hrhp_pkg::CLS_STATUS;
            end
         end
         hrhp_pkg::PH_REASON: begin
            if (b == CR_CHAR) ps_phase = hrhp_pkg::PH_SL_LF;
            else cls = hrhp_pkg::CLS_REASON;
         end
         hrhp_pkg::PH_SL_LF, hrhp_pkg::PH_HDR_LF: begin
            if (b == LF_CHAR) begin
               ps_phase = hrhp_pkg::PH_HDR_SPACE;
            end else begin
               raise_error(hrhp_pkg::ERR_NO_LF);
               cls = hrhp_pkg::CLS_DROP;
            end
         end
         hrhp_pkg::PH_HDR_SPACE: begin
            if (b == CR_CHAR) begin
               ps_phase = hrhp_pkg::PH_SEP_LF;
            end else if (b != SP_CHAR) begin
               ps_name_pos  = 4'd0;
               ps_name_hits = 3'b111;
               name_feed(b);
               cls      = hrhp_pkg::CLS_NAME;
               hid      = name_match();
               ps_phase = hrhp_pkg::PH_NAME;
            end
         end
         hrhp_pkg::PH_NAME: begin
            if (b == COLON_CHAR) begin
               ps_hdr   = name_match();
               hid      = ps_hdr;
               ps_phase = hrhp_pkg::PH_VAL_SPACE;
            end else begin
               name_feed(b);
               cls = hrhp_pkg::CLS_NAME;
               hid = name_match();
            end
         end
         hrhp_pkg::PH_VAL_SPACE, hrhp_pkg::PH_VALUE: begin
            if (b == CR_CHAR) begin
               ps_phase = hrhp_pkg::PH_HDR_LF;
            end else if (b != SP_CHAR || ps_phase == hrhp_pkg::PH_VALUE) begin
               cls      = hrhp_pkg::CLS_VALUE;
               hid      = ps_hdr;
               ps_phase = hrhp_pkg::PH_VALUE;
            end
         end
         hrhp_pkg::PH_SEP_LF: begin
            if (b == LF_CHAR) begin
               ps_phase = hrhp_pkg::PH_BODY;
            end else begin
               raise_error(hrhp_pkg::ERR_NO_LF);
               cls = hrhp_pkg::CLS_DROP;
            end
         end
         hrhp_pkg::PH_BODY: cls = hrhp_pkg::CLS_BODY;
         default: cls = hrhp_pkg::CLS_DROP;
      endcase
      r.byte_out   = b;
      r.byte_class = cls;
      r.header_id  = hid;
      r.status_200 = ps_status_good;
      r.error_code = ps_err;
      return r;
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic note_miss(input string what, input hrhp_pkg::rsp_type want,
                            input hrhp_pkg::rsp_type got);
      miss_count++;
      if (miss_count <= 10) begin
         $display("mismatch (%0s) at cycle %0d", what, cycle_count);
         $display("   expected byte %02h class %0d hdr %0d ok %0b err %0d",
                  want.byte_out, want.byte_class, want.header_id, want.status_200,
                  want.error_code);
         $display("   actual   byte %02h class %0d hdr %0d ok %0b err %0d",
                  got.byte_out, got.byte_class, got.header_id, got.status_200,
                  got.error_code);
      end
   endtask

   // predict on request accept, compare on result accept
   always @(posedge clock) begin : scoreboard
      hrhp_pkg::req_type seen;
      hrhp_pkg::rsp_type got;
      hrhp_pkg::rsp_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            seen.kind      = hrhp_pkg::kind_type'(req_bus.kind);
            seen.data_byte = req_bus.data_byte;
            tags_due.push_back(tag_byte(seen));
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.byte_out   = rsp_bus.byte_out;
            got.byte_class = hrhp_pkg::byte_class_type'(rsp_bus.byte_class);
            got.header_id  = hrhp_pkg::hdr_id_type'(rsp_bus.header_id);
            got.status_200 = rsp_bus.status_200;
            got.error_code = hrhp_pkg::err_type'(rsp_bus.error_code);
            if (tags_due.size() == 0) begin
               want = '0;
               note_miss("unexpected item", want, got);
            end else begin
               want = tags_due.pop_front();
               if (got.byte_out !== want.byte_out || got.byte_class !== want.byte_class ||
                   got.header_id !== want.header_id || got.status_200 !== want.status_200 ||
                   got.error_code !== want.error_code)
                  note_miss("field", want, got);
            end
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------------------------------------------------------- idling

   function automatic int pause_len();
      int r;
      int n;
      r = $urandom_range(0, 99);
      if (r < 60) n = $urandom_range(1, 2);
      else if (r < 90) n = $urandom_range(3, 6);
      else n = $urandom_range(10, 40);
      return n;
   endfunction

   // receiver back-pressure, with calm stretches of steady ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_bus.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (ready_calm != 0) ready_calm <= ready_calm - 1;
         else if ($urandom_range(0, 63) == 0) ready_calm <= $urandom_range(50, 200);
         else if ($urandom_range(0, 2) == 0) hold_left <= pause_len();
      end
   end

   // ---------------------------------------------------------------- stimulus

   task automatic send_item(input hrhp_pkg::req_type it);
      int gap;
      gap = 0;
      if (send_calm != 0) send_calm--;
      else if ($urandom_range(0, 49) == 0) send_calm = $urandom_range(50, 150);
      else if ($urandom_range(0, 1) == 1) gap = pause_len();
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.kind      <= it.kind;
      req_bus.data_byte <= it.data_byte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic flush_plan();
      while (byte_plan.size() != 0) send_item(byte_plan.pop_front());
   endtask

   function automatic void put_byte(input logic [7:0] b);
      hrhp_pkg::req_type it;
      it.kind      = hrhp_pkg::KIND_DATA;
      it.data_byte = b;
      byte_plan.push_back(it);
   endfunction

   // restart items carry a random byte that must be ignored
   function automatic void put_restart();
      hrhp_pkg::req_type it;
      it.kind      = hrhp_pkg::KIND_RESTART;
      it.data_byte = 8'($urandom_range(0, 255));
      byte_plan.push_back(it);
   endfunction

   function automatic void put_text(input string s);
      int k;
      for (k = 0; k < s.len(); k++) put_byte(s[k]);
   endfunction

   function automatic logic [7:0] byte_other_than(input logic [7:0] b);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == b);
      return v;
   endfunction

   function automatic logic [7:0] byte_other_than2(input logic [7:0] b, input logic [7:0] c);
      logic [7:0] v;
      do v = 8'($urandom_range(0, 255)); while (v == b || v == c);
      return v;
   endfunction

   function automatic string hdr_string(input int idx);
      string s;
      case (idx)
         0:       s = "Content-Length";
         1:       s = "Content-Type";
         default: s = "Last-Modified";
      endcase
      return s;
   endfunction

   // status token bytes: digits, line ends and anything but a space
   function automatic void put_status_junk(input int n);
      int k;
      int r;
      for (k = 0; k < n; k++) begin
         r = $urandom_range(0, 9);
         if (r < 5) put_byte(8'h30 + 8'($urandom_range(0, 9)));
         else if (r < 7) put_byte($urandom_range(0, 1) ? CR_CHAR : LF_CHAR);
         else put_byte(byte_other_than(SP_CHAR));
      end
   endfunction

   // a known name cut short, with one byte changed, or with a byte added
   function automatic void put_name_variant(input string s);
      int k;
      int cut;
      int swap;
      case ($urandom_range(0, 2))
         0: begin
            cut = $urandom_range(1, s.len() - 1);
            for (k = 0; k < cut; k++) put_byte(s[k]);
         end
         1: begin
            swap = $urandom_range(1, s.len() - 1);
            for (k = 0; k < s.len(); k++)
               put_byte(k == swap ? byte_other_than2(s[k], COLON_CHAR) : s[k]);
         end
         default: begin
            put_text(s);
            put_byte(byte_other_than(COLON_CHAR));
         end
      endcase
   endfunction

   function automatic void put_line_end();
      if ($urandom_range(0, 19) == 0) put_byte(byte_other_than(LF_CHAR));
      else put_byte(LF_CHAR);
   endfunction

   // one response, mostly well formed with random content
   function automatic void plan_response();
      int k;
      int n;
      put_restart();
      repeat ($urandom_range(0, 2)) put_byte(SP_CHAR);
      // protocol token
      case ($urandom_range(0, 9))
         0: begin
            n = $urandom_range(1, 18);
            for (k = 0; k < n; k++) put_byte(byte_other_than(SP_CHAR));
         end
         1: begin
            put_text("HTTP/1.");
            put_byte($urandom_range(0, 1) ? 8'h31 : byte_other_than2(SP_CHAR, 8'h30));
         end
         default: put_text("HTTP/1.0");
      endcase
      repeat ($urandom_range(1, 2)) put_byte(SP_CHAR);
      // status token
      case ($urandom_range(0, 9)) inside
         0, 1: put_status_junk($urandom_range(1, 18));
         2:    put_text("20");
         3:    put_text("2000");
         default: put_text("200");
      endcase
      put_byte(SP_CHAR);
      repeat ($urandom_range(0, 5)) put_byte(byte_other_than(CR_CHAR));
      put_byte(CR_CHAR);
      put_line_end();
      // header lines
      repeat ($urandom_range(0, 4)) begin
         repeat ($urandom_range(0, 2)) put_byte(SP_CHAR);
         case ($urandom_range(0, 9)) inside
            0, 1, 2, 3, 4, 5: put_text(hdr_string($urandom_range(0, 2)));
            6, 7: put_name_variant(hdr_string($urandom_range(0, 2)));
            8: begin
               n = $urandom_range(15, 20);
               put_byte(8'h41 + 8'($urandom_range(0, 25)));
               for (k = 1; k < n; k++) put_byte(byte_other_than(COLON_CHAR));
            end
            default: begin
               n = $urandom_range(1, 5);
               put_byte(8'h61 + 8'($urandom_range(0, 25)));
               for (k = 1; k < n; k++) put_byte(byte_other_than(COLON_CHAR));
            end
         endcase
         put_byte(COLON_CHAR);
         repeat ($urandom_range(0, 2)) put_byte(SP_CHAR);
         repeat ($urandom_range(0, 6)) put_byte(byte_other_than(CR_CHAR));
         put_byte(CR_CHAR);
         put_line_end();
      end
      // empty line, then body
      put_byte(CR_CHAR);
      put_line_end();
      repeat ($urandom_range(0, 6)) put_byte(8'($urandom_range(0, 255)));
   endfunction

   // ---------------------------------------------------------------- tests

   // wrong protocol latches an error and drops what follows
   task automatic test_bad_protocol();
      put_restart();
      put_byte(SP_CHAR);
      put_text("X");
      put_byte(SP_CHAR);
      put_byte(8'h00);
      put_byte(8'hFF);
      flush_plan();
   endtask

   // minimal good response: status 200, no headers, one body byte
   task automatic test_good_response();
      put_restart();
      put_text("HTTP/1.0 200 ");
      put_byte(CR_CHAR);
      put_byte(LF_CHAR);
      put_byte(CR_CHAR);
      put_byte(LF_CHAR);
      put_byte(8'hFF);
      flush_plan();
   endtask

   task automatic test_random_responses();
      while (sent_count < 1800) begin
         plan_response();
         flush_plan();
      end
   endtask

   // raw bytes with occasional restarts, special characters favoured
   task automatic test_noise();
      int r;
      repeat (200) begin
         r = $urandom_range(0, 99);
         if (r < 8) put_restart();
         else if (r < 40) begin
            case ($urandom_range(0, 3))
               0: put_byte(SP_CHAR);
               1: put_byte(COLON_CHAR);
               2: put_byte(CR_CHAR);
               default: put_byte(LF_CHAR);
            endcase
         end else put_byte(8'($urandom_range(0, 255)));
      end
      flush_plan();
   endtask

   initial begin
      clock = 1'b0;
      reset <= 1'b1;
      req_bus.valid     <= 1'b0;
      req_bus.kind      <= hrhp_pkg::KIND_DATA;
      req_bus.data_byte <= 8'h00;
      parser_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_bad_protocol();
      test_good_response();
      test_random_responses();
      test_noise();
      req_bus.valid <= 1'b0;
      while (tags_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (miss_count == 0 && tags_due.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule

[files.f]
hdl/hrhp_pkg.sv
hdl/hrhp_if.sv
hdl/hrhp_in_reg.sv
hdl/hrhp_parse.sv
hdl/hrhp_out_reg.sv
hdl/http_response_header_parser_unit.sv
hdl/hrhp_checker.sv
verif/tb.sv
